[src/mcrc_pkg.sv]
// Package: shared types, constants and the byte fold function of the CRC engine.
`default_nettype none
package mcrc_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned IN_TDATA_W = 40;
    localparam int unsigned IN_TUSER_W = 2;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h0000_1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDE_MODE  = 1'b0,
        CFG_POLYNOMIAL = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic             wide;
        logic [CRC_W-1:0] poly;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              first_byte;
        logic              last_byte;
        logic [CRC_W-1:0]  start_value;
    } item_t;

    // Eight MSB-first shift steps; bits above the active width are masked by the caller.
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic              wide,
        input logic [CRC_W-1:0]  gen
    );
        logic [CRC_W-1:0] c;
        logic             top;
        if (wide) begin
            c = crc_in ^ {data, 24'h0};
        end else begin
            c = crc_in ^ {16'h0, data, 8'h0};
        end
        for (int i = 0; i < BYTE_W; i++) begin
            top = wide ? c[31] : c[15];
            c   = {c[CRC_W-2:0], 1'b0} ^ (top ? gen : '0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[src/mcrc_cfg.sv]
// Configuration registers: width mode and generator polynomial.
`default_nettype none
module mcrc_cfg
    import mcrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CRC_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    logic             wide_reg;
    logic [CRC_W-1:0] poly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b0;
            poly_reg <= POLY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_WIDE_MODE:  wide_reg <= cfg_wdata[0];
                CFG_POLYNOMIAL: poly_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.wide = wide_reg;
    assign cfg.poly = poly_reg;

endmodule
`default_nettype wire

[src/mcrc_fold.sv]
// CRC datapath: seed select, byte fold and width mask.
`default_nettype none
module mcrc_fold
    import mcrc_pkg::*;
(
    input  wire cfg_t              cfg,
    input  wire item_t             item,
    input  wire logic [CRC_W-1:0]  crc_state,
    output logic      [CRC_W-1:0]  crc_next
);

    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] gen;
    logic [CRC_W-1:0] base;
    logic [CRC_W-1:0] folded;

    always_comb begin
        mask   = cfg.wide ? {CRC_W{1'b1}} : {16'h0, 16'hFFFF};
        gen    = cfg.poly & mask;
        base   = (item.first_byte ? item.start_value : crc_state) & mask;
        folded = fold_byte(base, item.data_byte, cfg.wide, gen) & mask;
        crc_next = item.byte_present ? folded : base;
    end

endmodule
`default_nettype wire

[src/msb_first_crc_engine_core.sv]
// Top level: MSB-first CRC engine with stream ports and a write-only config port.
// Each input transfer is held in the input register, and its result is registered in the result register.
// Throughput: one byte per cycle; the byte fold is one XOR network between the two registers.
// Stalls on the result side back up through the input register to s_tready.
// Reset (aresetn low, synchronous): both stages empty, running CRC 0, 16-bit mode,
// polynomial 0x1021.
`default_nettype none
module msb_first_crc_engine_core
    import mcrc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CRC_W-1:0]      cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] data_byte, [39:8] start_value
    input  wire logic [IN_TUSER_W-1:0] s_tuser,   // [0] byte_present, [1] first_byte
    input  wire logic                  s_tlast,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [CRC_W-1:0]      m_tdata,   // [31:0] crc_value
    output logic                       m_tlast
);

    cfg_t             cfg;
    item_t            item_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic [CRC_W-1:0] crc_reg;
    logic             msg_end_reg;
    logic [CRC_W-1:0] crc_next;
    logic             advance;
    logic             in_xfer;

    mcrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mcrc_fold u_fold (
        .cfg       (cfg),
        .item      (item_reg),
        .crc_state (crc_reg),
        .crc_next  (crc_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end else begin
            if (in_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg.data_byte    <= s_tdata[7:0];
            item_reg.start_value  <= s_tdata[39:8];
            item_reg.byte_present <= s_tuser[0];
            item_reg.first_byte   <= s_tuser[1];
            item_reg.last_byte    <= s_tlast;
        end
        if (advance) begin
            msg_end_reg <= item_reg.last_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = crc_reg;
    assign m_tlast  = msg_end_reg;

    // a stalled result keeps its CRC
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(crc_reg))
        else $error("stalled result lost or changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> in_valid_reg)
        else $error("accepted transfer not held in input stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item missing from result stage");

endmodule
`default_nettype wire
